### rtl/core/first_fit_block_allocator_defines.svh
// Assertion helpers used by the allocator datapath.
// Every property is sampled on clk_i and is disabled while rst_ni is low.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`define FFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define FFBA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/core/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  localparam int MemSizeDef = 4096;
  localparam int ReqW       = 13;
  localparam int OffW       = 12;
  localparam int StW        = 3;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef enum logic [StW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_NO_GAP    = 3'd2,
    ST_NO_BLOCK  = 3'd3,
    ST_ZERO_SIZE = 3'd4
  } status_e;

  typedef struct packed {
    logic    clr;
    logic    start;
    logic    scan;
    logic    wr_alloc;
    logic    wr_free;
    logic    set_res;
    status_e code;
    logic    push;
  } ffba_cmd_t;

  typedef struct packed {
    logic arena_rdy;
    logic in_mode;
    logic in_zero;
    logic in_oob;
    logic scan_win;
    logic scan_end;
    logic blk_used;
    logic clr_last;
    logic out_free;
  } ffba_stat_t;

endpackage

`default_nettype wire

### rtl/core/ffba_req_if.sv
`default_nettype none

interface ffba_req_if import ffba_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            mode;
  logic [ReqW-1:0] request_size;
  logic [OffW-1:0] block_offset;

  modport source (output valid, output mode, output request_size, output block_offset,
                  input ready);
  modport sink (input valid, input mode, input request_size, input block_offset,
                output ready);
endinterface

`default_nettype wire

### rtl/core/ffba_rsp_if.sv
`default_nettype none

interface ffba_rsp_if import ffba_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OffW-1:0] granted_offset;
  logic [StW-1:0]  status;

  modport source (output valid, output granted_offset, output status, input ready);
  modport sink (input valid, input granted_offset, input status, output ready);
endinterface

`default_nettype wire

### rtl/core/ffba_cfg_if.sv
`default_nettype none

interface ffba_cfg_if import ffba_pkg::*; ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/first_fit_block_allocator.sv
`default_nettype none

// First-fit allocator over an arena of MEM_SIZE bytes, kept as a table with one entry per start
// offset in a memory with one read port and one write port. After reset the table is cleared
// in a pass over every entry during which no request word is taken; configuration writes are
// taken at any time. An allocate walks the table one entry per clock through the memory read
// port and finishes early when a fitting gap is found. A request that fails without touching
// the table (arena not ready, zero size, offset outside the arena) goes straight to the result.
// One request is in work at a time; the result sits in an output register so the next request
// may be taken while it waits.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int MEM_SIZE = MemSizeDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffba_req_if.sink   req_i,
  ffba_rsp_if.source rsp_o,
  ffba_cfg_if.sink   cfg_i
);

  ffba_cmd_t  cmd;
  ffba_stat_t stat;
  logic       req_ready;

  assign req_i.ready = req_ready;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffba_dp #(
    .MEM_SIZE (MEM_SIZE)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mode_i (req_i.mode),
    .in_size_i (req_i.request_size),
    .in_off_i  (req_i.block_offset),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .rsp_o     (rsp_o),
    .cfg_i     (cfg_i)
  );

endmodule

`default_nettype wire

### rtl/core/ffba_ctrl.sv
`default_nettype none

module ffba_ctrl import ffba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  ffba_stat_t stat_i,
  output ffba_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_SCAN    = 6'b000100,
    S_FREE_EV = 6'b001000,
    S_WRITE   = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.code   = ST_OK;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (!stat_i.arena_rdy) begin
            cmd_o.set_res = 1'b1;
            cmd_o.code    = ST_NOT_READY;
            state_d       = S_DONE;
          end else if (stat_i.in_mode == ModeAlloc) begin
            if (stat_i.in_zero) begin
              cmd_o.set_res = 1'b1;
              cmd_o.code    = ST_ZERO_SIZE;
              state_d       = S_DONE;
            end else begin
              cmd_o.start = 1'b1;
              state_d     = S_SCAN;
            end
          end else if (stat_i.in_oob) begin
            cmd_o.set_res = 1'b1;
            cmd_o.code    = ST_NO_BLOCK;
            state_d       = S_DONE;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = S_FREE_EV;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_win) begin
          state_d = S_WRITE;
        end else if (stat_i.scan_end) begin
          cmd_o.set_res = 1'b1;
          cmd_o.code    = ST_NO_GAP;
          state_d       = S_DONE;
        end
      end
      S_FREE_EV: begin
        cmd_o.set_res = 1'b1;
        state_d       = S_DONE;
        if (stat_i.blk_used) begin
          cmd_o.wr_free = 1'b1;
          cmd_o.code    = ST_OK;
        end else begin
          cmd_o.code = ST_NO_BLOCK;
        end
      end
      S_WRITE: begin
        cmd_o.wr_alloc = 1'b1;
        cmd_o.set_res  = 1'b1;
        cmd_o.code     = ST_OK;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ffba_dp.sv
`default_nettype none
`include "first_fit_block_allocator_defines.svh"

module ffba_dp import ffba_pkg::*; #(
  parameter int MEM_SIZE = MemSizeDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_mode_i,
  input  logic [ReqW-1:0] in_size_i,
  input  logic [OffW-1:0] in_off_i,
  input  ffba_cmd_t       cmd_i,
  output ffba_stat_t      stat_o,
  ffba_rsp_if.source      rsp_o,
  ffba_cfg_if.sink        cfg_i
);

  localparam int AW   = $clog2(MEM_SIZE);
  localparam int CW   = $clog2(MEM_SIZE + 1);
  localparam int SW   = CW;
  localparam int EW   = SW + 1;
  localparam int SkW  = CW + 1;
  localparam int CmpW = (CW > ReqW) ? CW : ReqW;

  // Each table entry holds the allocated flag in its top bit and the block size below it.
  logic [EW-1:0] table_q [MEM_SIZE];
  logic [EW-1:0] rdata_q;

  logic            arena_q;
  logic            mode_q;
  logic [ReqW-1:0] size_q;
  logic [AW-1:0]   off_q;
  logic [CW-1:0]   cnt_q;
  logic            ev_vld_q;
  logic [AW-1:0]   ev_addr_q;
  logic [SkW-1:0]  skip_q;
  logic            gap_q;
  logic [AW-1:0]   gs_q;
  logic [AW-1:0]   clr_q;
  status_e         res_code_q;
  logic [OffW-1:0] res_off_q;
  logic            rsp_vld_q;
  status_e         rsp_code_q;
  logic [OffW-1:0] rsp_off_q;

  logic            issue;
  logic [AW-1:0]   rd_addr;
  logic            we;
  logic [AW-1:0]   wa;
  logic [EW-1:0]   wd;
  logic [SkW-1:0]  a_ext;
  logic            e_used;
  logic [SW-1:0]   e_size;
  logic            live;
  logic [AW-1:0]   gstart;
  logic [CW-1:0]   len;
  logic            win;

  assign issue = (cnt_q < CW'(MEM_SIZE));

  always_comb begin
    if (cmd_i.start) begin
      rd_addr = (in_mode_i == ModeFree) ? AW'(in_off_i) : '0;
    end else if (issue) begin
      rd_addr = cnt_q[AW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  assign we = cmd_i.clr || cmd_i.wr_alloc || cmd_i.wr_free;

  always_comb begin
    if (cmd_i.clr) begin
      wa = clr_q;
    end else if (cmd_i.wr_alloc) begin
      wa = gs_q;
    end else begin
      wa = off_q;
    end
  end

  assign wd = cmd_i.wr_alloc ? {1'b1, SW'(size_q)} : '0;

  always_ff @(posedge clk_i) begin
    if (we) begin
      table_q[wa] <= wd;
    end
    rdata_q <= table_q[rd_addr];
  end

  // A gap counts as soon as the free run seen so far covers the request.
  assign a_ext  = SkW'(ev_addr_q);
  assign e_used = rdata_q[EW-1];
  assign e_size = rdata_q[SW-1:0];
  assign live   = ev_vld_q && (a_ext >= skip_q);
  assign gstart = gap_q ? gs_q : ev_addr_q;
  assign len    = CW'(ev_addr_q - gstart) + CW'(1);
  assign win    = live && !e_used && (CmpW'(len) >= CmpW'(size_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q   <= 1'b0;
      cnt_q     <= '0;
      ev_vld_q  <= 1'b0;
      skip_q    <= '0;
      gap_q     <= 1'b0;
      clr_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        arena_q <= cfg_i.data;
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.start) begin
        cnt_q    <= (in_mode_i == ModeAlloc) ? CW'(1) : '0;
        ev_vld_q <= (in_mode_i == ModeAlloc);
        skip_q   <= '0;
        gap_q    <= 1'b0;
      end else if (cmd_i.scan) begin
        if (issue) begin
          cnt_q    <= cnt_q + CW'(1);
          ev_vld_q <= 1'b1;
        end else begin
          ev_vld_q <= 1'b0;
        end
        if (live) begin
          if (e_used) begin
            skip_q <= a_ext + SkW'(e_size);
            gap_q  <= 1'b0;
          end else begin
            gap_q <= 1'b1;
          end
        end
      end
      if (cmd_i.push) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q    <= in_mode_i;
      size_q    <= in_size_i;
      off_q     <= AW'(in_off_i);
      ev_addr_q <= '0;
    end else if (cmd_i.scan) begin
      if (issue) begin
        ev_addr_q <= cnt_q[AW-1:0];
      end
      if (live && !e_used) begin
        gs_q <= gstart;
      end
    end
    if (cmd_i.set_res) begin
      res_code_q <= cmd_i.code;
      res_off_q  <= (cmd_i.code == ST_OK && mode_q == ModeAlloc) ? OffW'(gs_q) : '0;
    end
    if (cmd_i.push) begin
      rsp_code_q <= res_code_q;
      rsp_off_q  <= res_off_q;
    end
  end

  assign stat_o.arena_rdy = arena_q;
  assign stat_o.in_mode   = in_mode_i;
  assign stat_o.in_zero   = (in_size_i == '0);
  assign stat_o.in_oob    = (32'(in_off_i) >= 32'(MEM_SIZE));
  assign stat_o.scan_win  = win;
  assign stat_o.scan_end  = !ev_vld_q;
  assign stat_o.blk_used  = e_used;
  assign stat_o.clr_last  = (clr_q == AW'(MEM_SIZE - 1));
  assign stat_o.out_free  = !rsp_vld_q || rsp_o.ready;

  assign cfg_i.ready          = 1'b1;
  assign rsp_o.valid          = rsp_vld_q;
  assign rsp_o.granted_offset = rsp_off_q;
  assign rsp_o.status         = rsp_code_q;

  `FFBA_ASSERT(a_no_zero_block, cmd_i.wr_alloc |-> (size_q != '0), "zero-size block recorded")
  `FFBA_ASSERT(a_grant_fits, cmd_i.wr_alloc |-> (32'(gs_q) + 32'(size_q) <= 32'(MEM_SIZE)), "granted block runs past the arena end")
  `FFBA_ASSERT(a_push_room, cmd_i.push |-> (!rsp_vld_q || rsp_o.ready), "result overwrites a word not yet taken")
  `FFBA_ASSERT(a_clear_alone, cmd_i.clr |-> !(cmd_i.start || cmd_i.scan || cmd_i.wr_alloc || cmd_i.wr_free), "table access during the clearing pass")
  `FFBA_ASSERT_NEXT(a_grant_loaded, cmd_i.wr_alloc, res_code_q == ST_OK && res_off_q == OffW'(gs_q), "granted offset not loaded into the result")

endmodule

`default_nettype wire

### dv/first_fit_block_allocator_tb.sv
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int MemSize       = MemSizeDef;
  localparam int WatchdogLimit = 20000;
  localparam int HoldCycles    = 400;
  localparam int RandomBatches = 7;
  localparam int BatchLen      = 16;
  localparam int MaxReported   = 10;

  typedef struct packed {
    logic            mode;
    logic [ReqW-1:0] request_size;
    logic [OffW-1:0] block_offset;
  } alloc_req_t;

  typedef struct packed {
    logic [OffW-1:0] granted_offset;
    status_e         status;
  } grant_t;

  logic clk_i;
  logic rst_ni;

  ffba_req_if req_bus ();
  ffba_rsp_if rsp_bus ();
  ffba_cfg_if cfg_bus ();

  first_fit_block_allocator #(
    .MEM_SIZE(MemSize)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus),
    .cfg_i (cfg_bus)
  );

  bit          shadow_used [MemSize];
  int unsigned shadow_len  [MemSize];
  logic        shadow_ready;

  alloc_req_t request_words[$];
  grant_t     expected_grants[$];

  int req_accepted   = 0;
  int mismatch_count = 0;
  int idle_cycles    = 0;
  int send_gap       = 0;
  int rsp_stall      = 0;
  bit steady_flow    = 1'b0;
  bit rsp_hold       = 1'b0;

  initial begin
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.mode         = ModeAlloc;
    req_bus.request_size = '0;
    req_bus.block_offset = '0;
    rsp_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.data         = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic grant_t predict_grant(alloc_req_t w);
    grant_t g;
    int     pos;
    int     nxt;
    g.granted_offset = '0;
    g.status         = ST_NO_GAP;
    if (!shadow_ready) begin
      g.status = ST_NOT_READY;
      return g;
    end
    if (w.mode == ModeFree) begin
      if (int'(w.block_offset) >= MemSize || !shadow_used[w.block_offset]) begin
        g.status = ST_NO_BLOCK;
      end else begin
        shadow_used[w.block_offset] = 1'b0;
        shadow_len[w.block_offset]  = 0;
        g.status                    = ST_OK;
      end
      return g;
    end
    if (w.request_size == '0) begin
      g.status = ST_ZERO_SIZE;
      return g;
    end
    pos = 0;
    while (pos < MemSize) begin
      if (shadow_used[pos]) begin
        pos += (shadow_len[pos] == 0) ? 1 : int'(shadow_len[pos]);
      end else begin
        nxt = pos + 1;
        while (nxt < MemSize && !shadow_used[nxt]) nxt++;
        if (nxt - pos >= int'(w.request_size)) begin
          shadow_used[pos] = 1'b1;
          shadow_len[pos]  = w.request_size;
          g.granted_offset = pos[OffW-1:0];
          g.status         = ST_OK;
          return g;
        end
        pos = nxt;
      end
    end
    return g;
  endfunction

  function automatic int idle_length();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ReqW-1:0] random_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return ReqW'($urandom_range(1, 64));
    if (r < 90) return ReqW'($urandom_range(65, 512));
    if (r < 98) return ReqW'($urandom_range(513, 2048));
    return ReqW'($urandom_range(2049, MemSize));
  endfunction

  function automatic alloc_req_t req_word(logic mode, int size, int offset);
    alloc_req_t w;
    w.mode         = mode;
    w.request_size = ReqW'(size);
    w.block_offset = OffW'(offset);
    return w;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatch_count < MaxReported) $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_words.size() != 0 || req_bus.valid || expected_grants.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_arena_ready(logic value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk_i);
    while (cfg_bus.ready !== 1'b1);
    shadow_ready = value;
    cfg_bus.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Most words are allocations and frees of live blocks; the rest are frees at random or
  // interior offsets and allocations of zero, full-arena or oversized length.
  task automatic queue_random_batch(int n);
    int         live[$];
    int         pick;
    int         o;
    int         r;
    alloc_req_t w;
    for (int i = 0; i < MemSize; i++) begin
      if (shadow_used[i]) live.push_back(i);
    end
    for (int k = 0; k < n; k++) begin
      r              = $urandom_range(0, 99);
      w.mode         = ModeAlloc;
      w.request_size = random_size();
      w.block_offset = OffW'($urandom_range(0, MemSize - 1));
      if (r >= 50 && r < 95) begin
        w.mode         = ModeFree;
        w.request_size = ReqW'($urandom_range(0, (1 << ReqW) - 1));
        if (r < 85 && live.size() > 0) begin
          pick           = $urandom_range(0, live.size() - 1);
          w.block_offset = OffW'(live[pick]);
          live.delete(pick);
        end else if (r < 90 && live.size() > 0) begin
          o = live[$urandom_range(0, live.size() - 1)];
          if (shadow_len[o] > 1) begin
            w.block_offset = OffW'(o + $urandom_range(1, shadow_len[o] - 1));
          end
        end
      end else if (r >= 95) begin
        case ($urandom_range(0, 2))
          0: w.request_size = '0;
          1: w.request_size = ReqW'(MemSize);
          default: w.request_size = ReqW'($urandom_range(MemSize + 1, (1 << ReqW) - 1));
        endcase
      end
      request_words.push_back(w);
    end
  endtask

  always @(posedge clk_i) begin : request_driver
    alloc_req_t w;
    logic       fire;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      send_gap      <= 0;
    end else begin
      fire = req_bus.valid && req_bus.ready;
      if (fire) begin
        expected_grants.push_back(predict_grant(alloc_req_t'({req_bus.mode,
            req_bus.request_size, req_bus.block_offset})));
        req_accepted <= req_accepted + 1;
      end
      if (!req_bus.valid || fire) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          req_bus.valid <= 1'b0;
        end else if (request_words.size() > 0) begin
          w = request_words.pop_front();
          req_bus.valid        <= 1'b1;
          req_bus.mode         <= w.mode;
          req_bus.request_size <= w.request_size;
          req_bus.block_offset <= w.block_offset;
          send_gap             <= idle_length();
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : response_ready
    int stall;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      rsp_stall     <= 0;
    end else if (rsp_hold) begin
      rsp_bus.ready <= 1'b0;
    end else if (rsp_bus.valid && rsp_bus.ready) begin
      stall = idle_length();
      if (stall == 0) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= 1'b0;
        rsp_stall     <= stall - 1;
      end
    end else if (rsp_stall > 0) begin
      rsp_stall     <= rsp_stall - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : response_monitor
    grant_t g;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_grants.size() == 0) begin
        flag_mismatch($sformatf("unexpected word: granted_offset %0d status %0d",
            rsp_bus.granted_offset, rsp_bus.status));
      end else begin
        g = expected_grants.pop_front();
        if (rsp_bus.granted_offset !== g.granted_offset || rsp_bus.status !== g.status) begin
          flag_mismatch($sformatf("granted_offset %0d status %0d, expected %0d status %0d",
              rsp_bus.granted_offset, rsp_bus.status, g.granted_offset, g.status));
        end
      end
    end
  end

  // The receiver holds off long enough for the allocator to fill up and stall its input.
  initial begin : response_hold_off
    do @(negedge clk_i);
    while (!(req_accepted >= 40 && request_words.size() >= 8));
    rsp_hold = 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    rsp_hold = 1'b0;
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("first_fit_block_allocator_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    shadow_ready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    request_words.push_back(req_word(ModeAlloc, 16, 0));
    request_words.push_back(req_word(ModeFree, 0, 0));
    request_words.push_back(req_word(ModeAlloc, 0, 4095));
    wait_drained();
    write_arena_ready(1'b1);

    request_words.push_back(req_word(ModeAlloc, 0, 4095));
    request_words.push_back(req_word(ModeAlloc, 8191, 0));
    request_words.push_back(req_word(ModeAlloc, 4097, 0));
    request_words.push_back(req_word(ModeAlloc, 4096, 0));
    request_words.push_back(req_word(ModeAlloc, 1, 0));
    request_words.push_back(req_word(ModeFree, 8191, 1));
    request_words.push_back(req_word(ModeFree, 0, 4095));
    request_words.push_back(req_word(ModeFree, 0, 0));
    request_words.push_back(req_word(ModeFree, 0, 0));
    request_words.push_back(req_word(ModeAlloc, 100, 0));
    request_words.push_back(req_word(ModeAlloc, 50, 0));
    request_words.push_back(req_word(ModeAlloc, 1, 0));
    request_words.push_back(req_word(ModeFree, 0, 100));
    request_words.push_back(req_word(ModeAlloc, 30, 0));
    request_words.push_back(req_word(ModeAlloc, 30, 0));
    request_words.push_back(req_word(ModeAlloc, 3915, 0));
    request_words.push_back(req_word(ModeAlloc, 20, 0));
    request_words.push_back(req_word(ModeAlloc, 1, 0));
    request_words.push_back(req_word(ModeFree, 0, 181));
    wait_drained();

    for (int b = 0; b < RandomBatches; b++) begin
      if (b == 3) begin
        write_arena_ready(1'b0);
        queue_random_batch(4);
        wait_drained();
        write_arena_ready(1'b1);
      end
      steady_flow = ($urandom_range(0, 3) == 0);
      queue_random_batch(BatchLen);
      wait_drained();
    end
    steady_flow = 1'b0;

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_grants.size() == 0) begin
      $display("first_fit_block_allocator_tb: clean");
    end else begin
      $display("first_fit_block_allocator_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ffba_pkg.sv
rtl/core/ffba_req_if.sv
rtl/core/ffba_rsp_if.sv
rtl/core/ffba_cfg_if.sv
rtl/core/ffba_ctrl.sv
rtl/core/ffba_dp.sv
rtl/core/first_fit_block_allocator.sv
dv/first_fit_block_allocator_tb.sv
